// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication between two expressions on the same clock.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== design/lfuc_pkg.sv =====
// Shared types and constants of the LFU cache.
package lfuc_pkg;
	localparam int ENTRIES_DEF = 16;
	localparam int COUNT_BITS_DEF = 32;
	localparam int CAP_BITS = 5;
	localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_LOOK,
		OP_STEP,
		OP_HIT,
		OP_MISS,
		OP_FILL,
		OP_EVICT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic kind;
		logic capz;
		logic room;
		logic scan_last;
	} status_t;
endpackage

// ===== design/lfuc_if.sv =====
// Channel interfaces: request, response and capacity write.
interface lfuc_req_if;
	logic valid;
	logic ready;
	logic kind;
	logic signed [31:0] key;
	logic signed [31:0] value;
	modport source (output valid, kind, key, value, input ready);
	modport sink (input valid, kind, key, value, output ready);
endinterface

interface lfuc_rsp_if;
	logic valid;
	logic ready;
	logic hit;
	logic signed [31:0] read_value;
	logic evicted;
	logic signed [31:0] evicted_key;
	modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
	modport sink (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

interface lfuc_cfg_if;
	logic valid;
	logic ready;
	logic [4:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== design/lfu_cache_lru_tiebreak_unit.sv =====
// Flow: a request is taken in idle, looked up, then applied (hit, get miss or fill)
// and its result registered; an eviction first runs the one-entry-per-cycle min-count scan.
// A new request is taken only after the previous one has loaded its result;
// a pending response does not block the next request transfer.
// Reset: valid marks and occupancy clear at once, capacity returns to 16.
module lfu_cache_lru_tiebreak_unit #(
	parameter int ENTRIES = lfuc_pkg::ENTRIES_DEF,
	parameter int COUNT_BITS = lfuc_pkg::COUNT_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	lfuc_req_if.sink req,
	lfuc_rsp_if.source rsp,
	lfuc_cfg_if.sink cfg
);
	import lfuc_pkg::*;

	cmd_t cmd;
	status_t status;
	logic [31:0] res_value, res_evicted_key;

	assign cfg.ready = 1'b1;

	lfuc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.status(status),
		.cmd(cmd)
	);

	lfuc_dp #(
		.ENTRIES(ENTRIES),
		.COUNT_BITS(COUNT_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.in_kind(req.kind),
		.in_key(req.key),
		.in_value(req.value),
		.cfg_we(cfg.valid),
		.cfg_data(cfg.data),
		.res_hit(rsp.hit),
		.res_value(res_value),
		.res_evicted(rsp.evicted),
		.res_evicted_key(res_evicted_key)
	);

	assign rsp.read_value = res_value;
	assign rsp.evicted_key = res_evicted_key;
endmodule

// ===== design/lfuc_dp.sv =====
// Datapath: entry table, lookup, eviction scan and result register.
module lfuc_dp #(
	parameter int ENTRIES = lfuc_pkg::ENTRIES_DEF,
	parameter int COUNT_BITS = lfuc_pkg::COUNT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  lfuc_pkg::cmd_t cmd,
	output lfuc_pkg::status_t status,
	input  logic in_kind,
	input  logic [31:0] in_key,
	input  logic [31:0] in_value,
	input  logic cfg_we,
	input  logic [lfuc_pkg::CAP_BITS-1:0] cfg_data,
	output logic res_hit,
	output logic [31:0] res_value,
	output logic res_evicted,
	output logic [31:0] res_evicted_key
);
	import lfuc_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OW = $clog2(ENTRIES + 1);
	localparam int CW = (OW > CAP_BITS) ? OW : CAP_BITS;
	localparam logic [CW-1:0] N_CW = CW'(ENTRIES);
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

	logic [ENTRIES-1:0] valid_q;
	logic [31:0] key_q [ENTRIES];
	logic [31:0] data_q [ENTRIES];
	logic [COUNT_BITS-1:0] cnt_q [ENTRIES];
	logic [IW-1:0] rank_q [ENTRIES];
	logic [OW-1:0] occ_q;
	logic [CAP_BITS-1:0] cap_q;

	logic kind_q;
	logic [31:0] ikey_q, ival_q;

	logic hit_q, room_q, capz_q, have_q;
	logic [IW-1:0] slot_q, scan_idx_q, slot_rank_q;
	logic [31:0] slot_data_q, best_key_q;
	logic [COUNT_BITS-1:0] best_cnt_q;

	logic [ENTRIES-1:0] hit_vec;
	logic [IW-1:0] hit_idx, free_idx;
	logic [CW-1:0] cap_ext, cap_eff;
	logic better;
	logic promote_all;
	logic [IW-1:0] lim;

	always_comb begin
		hit_idx = '0;
		free_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			hit_vec[i] = valid_q[i] && (key_q[i] == ikey_q);
			if (hit_vec[i])
				hit_idx = IW'(i);
			if (!valid_q[i])
				free_idx = IW'(i);
		end
	end

	assign cap_ext = CW'(cap_q);
	assign cap_eff = (cap_ext > N_CW) ? N_CW : cap_ext;

	// Lower count wins; on equal count the older (higher rank) entry wins.
	assign better = valid_q[scan_idx_q] && (!have_q || (cnt_q[scan_idx_q] < best_cnt_q) ||
		((cnt_q[scan_idx_q] == best_cnt_q) && (rank_q[scan_idx_q] > slot_rank_q)));

	assign status.hit = hit_q;
	assign status.kind = kind_q;
	assign status.capz = capz_q;
	assign status.room = room_q;
	assign status.scan_last = (scan_idx_q == LAST_IDX);

	assign promote_all = (cmd.op == OP_FILL);
	assign lim = slot_rank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q <= '0;
			cap_q <= CAP_RESET;
		end else begin
			if (cfg_we)
				cap_q <= cfg_data;
			if (cmd.op == OP_FILL) begin
				valid_q[slot_q] <= 1'b1;
				occ_q <= occ_q + OW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				kind_q <= in_kind;
				ikey_q <= in_key;
				ival_q <= in_value;
			end
			OP_LOOK: begin
				hit_q <= |hit_vec;
				slot_q <= (|hit_vec) ? hit_idx : free_idx;
				slot_rank_q <= rank_q[hit_idx];
				slot_data_q <= data_q[hit_idx];
				room_q <= CW'(occ_q) < cap_eff;
				capz_q <= (cap_eff == '0);
				scan_idx_q <= '0;
				have_q <= 1'b0;
			end
			OP_STEP: begin
				if (better) begin
					have_q <= 1'b1;
					slot_q <= scan_idx_q;
					slot_rank_q <= rank_q[scan_idx_q];
					best_cnt_q <= cnt_q[scan_idx_q];
					best_key_q <= key_q[scan_idx_q];
				end
				scan_idx_q <= scan_idx_q + IW'(1);
			end
			OP_HIT: begin
				if (!(&cnt_q[slot_q]))
					cnt_q[slot_q] <= cnt_q[slot_q] + COUNT_BITS'(1);
				if (kind_q)
					data_q[slot_q] <= ival_q;
				res_hit <= 1'b1;
				res_value <= kind_q ? 32'd0 : slot_data_q;
				res_evicted <= 1'b0;
				res_evicted_key <= '0;
			end
			OP_MISS: begin
				res_hit <= 1'b0;
				res_value <= kind_q ? 32'd0 : '1;
				res_evicted <= 1'b0;
				res_evicted_key <= '0;
			end
			OP_FILL, OP_EVICT: begin
				key_q[slot_q] <= ikey_q;
				data_q[slot_q] <= ival_q;
				cnt_q[slot_q] <= COUNT_BITS'(1);
				res_hit <= 1'b0;
				res_value <= '0;
				res_evicted <= (cmd.op == OP_EVICT);
				res_evicted_key <= (cmd.op == OP_EVICT) ? best_key_q : 32'd0;
			end
			default: ;
		endcase
		// Recency update: the touched entry becomes rank 0, younger ones age; a fill ages every valid entry.
		if (cmd.op == OP_HIT || cmd.op == OP_FILL || cmd.op == OP_EVICT) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (IW'(i) == slot_q)
					rank_q[i] <= '0;
				else if (valid_q[i] && (promote_all || rank_q[i] < lim))
					rank_q[i] <= rank_q[i] + IW'(1);
			end
		end
	end
endmodule

// ===== design/lfuc_ctrl.sv =====
// Controller: sequences lookup, update, eviction scan and result transfer.
module lfuc_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	input  lfuc_pkg::status_t status,
	output lfuc_pkg::cmd_t cmd
);
	import lfuc_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOOK = 3'd1;
	localparam logic [2:0] ST_APPLY = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_EVICT = 3'd4;

	logic [2:0] state_q, state_d;
	logic valid_q;
	logic out_free;
	logic res_load;

	assign out_free = !valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = valid_q;

	always_comb begin
		state_d = state_q;
		cmd.op = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.op = OP_LOAD;
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				cmd.op = OP_LOOK;
				state_d = ST_APPLY;
			end
			ST_APPLY: begin
				priority if (status.hit) begin
					if (out_free) begin
						cmd.op = OP_HIT;
						state_d = ST_IDLE;
					end
				end else if (!status.kind || status.capz) begin
					if (out_free) begin
						cmd.op = OP_MISS;
						state_d = ST_IDLE;
					end
				end else if (status.room) begin
					if (out_free) begin
						cmd.op = OP_FILL;
						state_d = ST_IDLE;
					end
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.op = OP_STEP;
				if (status.scan_last)
					state_d = ST_EVICT;
			end
			ST_EVICT: begin
				if (out_free) begin
					cmd.op = OP_EVICT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign res_load = (cmd.op == OP_HIT) || (cmd.op == OP_MISS) ||
		(cmd.op == OP_FILL) || (cmd.op == OP_EVICT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_load)
				valid_q <= 1'b1;
			else if (rsp_ready)
				valid_q <= 1'b0;
		end
	end
endmodule

// ===== design/lfuc_chk.sv =====
// Port-level checker for the LFU cache and its bind.
`include "assert_macros.svh"

module lfuc_chk (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic rsp_hit,
	input logic [31:0] rsp_read_value,
	input logic rsp_evicted,
	input logic [31:0] rsp_evicted_key
);
	`ASSERT_CLK(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value) && $stable(rsp_evicted_key), "stalled response changed")
	`ASSERT_IMPL(a_evict_not_hit, clk, arst_n, rsp_valid && rsp_evicted, !rsp_hit, "eviction on a hit")
	`ASSERT_IMPL(a_evkey_zero, clk, arst_n, rsp_valid && !rsp_evicted, rsp_evicted_key == 32'd0, "evicted key not zero")
	`ASSERT_IMPL(a_miss_value, clk, arst_n, rsp_valid && !rsp_hit, rsp_read_value == 32'd0 || rsp_read_value == 32'hffff_ffff, "bad miss value")
endmodule

bind lfu_cache_lru_tiebreak_unit lfuc_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_hit(rsp.hit),
	.rsp_read_value(rsp.read_value),
	.rsp_evicted(rsp.evicted),
	.rsp_evicted_key(rsp.evicted_key)
);
